// ===== rtl/touch_swipe_gesture_detector_defines.svh =====
// ----------------------------------------------------------------------------
// Touch swipe gesture detector: assertion macros
// Shared assertion helpers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SWIPE_GESTURE_DETECTOR_DEFINES_SVH
`define TOUCH_SWIPE_GESTURE_DETECTOR_DEFINES_SVH

// Same-cycle implication.
`define TSGD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TSGD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tsgd_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch swipe gesture detector package
// Widths, gesture codes, register indexes and configuration reset values.
// ----------------------------------------------------------------------------
package tsgd_pkg;

	// Default parameter values.
	localparam int COORD_BITS_DEF = 12;
	localparam int TIME_BITS_DEF  = 32;

	// Fixed field widths.
	localparam int ID_W      = 7;
	localparam int GEST_W    = 3;
	localparam int DIST_W    = 12;
	localparam int TMO_W     = 16;
	localparam int MID_W     = 12;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Gesture codes.
	localparam logic [GEST_W-1:0] G_NONE   = 3'd0;
	localparam logic [GEST_W-1:0] G_UP     = 3'd1;
	localparam logic [GEST_W-1:0] G_DOWN   = 3'd2;
	localparam logic [GEST_W-1:0] G_LEFT   = 3'd3;
	localparam logic [GEST_W-1:0] G_RIGHT  = 3'd4;
	localparam logic [GEST_W-1:0] G_LCLICK = 3'd5;
	localparam logic [GEST_W-1:0] G_RCLICK = 3'd6;
	localparam logic [GEST_W-1:0] G_CREATE = 3'd7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIDPOINT = 2'd2;

	// Configuration reset values.
	localparam logic [DIST_W-1:0] MIN_DIST_RST = 12'd300;
	localparam logic [TMO_W-1:0]  TIMEOUT_RST  = 16'd1200;
	localparam logic [MID_W-1:0]  MIDPOINT_RST = 12'd960;

	// Configuration register bundle.
	typedef struct packed {
		logic [DIST_W-1:0] min_dist;
		logic [TMO_W-1:0]  timeout;
		logic [MID_W-1:0]  midpoint;
	} cfg_t;

endpackage

// ===== rtl/tsgd_cfg.sv =====
// ----------------------------------------------------------------------------
// Touch swipe gesture detector: configuration registers
// Holds the swipe distance, swipe timeout and click midpoint registers.
// ----------------------------------------------------------------------------
module tsgd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tsgd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsgd_pkg::CFG_W-1:0]     cfg_data,
	output tsgd_pkg::cfg_t                 cfg
);

	tsgd_pkg::cfg_t cfg_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_dist <= tsgd_pkg::MIN_DIST_RST;
			cfg_q.timeout  <= tsgd_pkg::TIMEOUT_RST;
			cfg_q.midpoint <= tsgd_pkg::MIDPOINT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tsgd_pkg::REG_MIN_DIST: cfg_q.min_dist <= cfg_data[tsgd_pkg::DIST_W-1:0];
				tsgd_pkg::REG_TIMEOUT:  cfg_q.timeout  <= cfg_data[tsgd_pkg::TMO_W-1:0];
				tsgd_pkg::REG_MIDPOINT: cfg_q.midpoint <= cfg_data[tsgd_pkg::MID_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/tsgd_swipe.sv =====
// ----------------------------------------------------------------------------
// Touch swipe gesture detector: swipe classifier
// Turns a finished stroke into a swipe direction, or none when it was too
// slow or too short.
// ----------------------------------------------------------------------------
module tsgd_swipe #(
	parameter int COORD_BITS = tsgd_pkg::COORD_BITS_DEF,
	parameter int TIME_BITS  = tsgd_pkg::TIME_BITS_DEF
) (
	input  logic [COORD_BITS-1:0]           start_x,
	input  logic [COORD_BITS-1:0]           start_y,
	input  logic [COORD_BITS-1:0]           recent_x,
	input  logic [COORD_BITS-1:0]           recent_y,
	input  logic [TIME_BITS-1:0]            start_time,
	input  logic [TIME_BITS-1:0]            now_ms,
	input  logic [tsgd_pkg::DIST_W-1:0]     min_dist,
	input  logic [tsgd_pkg::TMO_W-1:0]      timeout,
	output logic [tsgd_pkg::GEST_W-1:0]     gesture
);

	localparam int CMP_W = (COORD_BITS > tsgd_pkg::DIST_W) ? COORD_BITS : tsgd_pkg::DIST_W;

	logic [COORD_BITS:0]   dx;
	logic [COORD_BITS:0]   dy;
	logic [COORD_BITS-1:0] ax;
	logic [COORD_BITS-1:0] ay;
	logic [COORD_BITS-1:0] big;
	logic [TIME_BITS-1:0]  elapsed;
	logic                  too_slow;
	logic                  too_short;

	// Signed travel on each axis and its magnitude.
	assign dx = {1'b0, recent_x} - {1'b0, start_x};
	assign dy = {1'b0, recent_y} - {1'b0, start_y};
	assign ax = dx[COORD_BITS] ? (~dx[COORD_BITS-1:0] + 1'b1) : dx[COORD_BITS-1:0];
	assign ay = dy[COORD_BITS] ? (~dy[COORD_BITS-1:0] + 1'b1) : dy[COORD_BITS-1:0];
	assign big = (ax > ay) ? ax : ay;

	// Stroke duration wraps with the free-running clock.
	assign elapsed   = now_ms - start_time;
	assign too_slow  = elapsed > TIME_BITS'(timeout);
	assign too_short = CMP_W'(big) < CMP_W'(min_dist);

	// Dominant axis wins; a tie goes to the horizontal axis.
	always_comb begin
		if (too_slow || too_short) begin
			gesture = tsgd_pkg::G_NONE;
		end else if (ax >= ay) begin
			gesture = dx[COORD_BITS] ? tsgd_pkg::G_LEFT : tsgd_pkg::G_RIGHT;
		end else begin
			gesture = dy[COORD_BITS] ? tsgd_pkg::G_UP : tsgd_pkg::G_DOWN;
		end
	end

endmodule

// ===== rtl/tsgd_step.sv =====
// ----------------------------------------------------------------------------
// Touch swipe gesture detector: sample step
// Holds the button edge and stroke tracking state and works out the gesture
// for the sample in the input register.
// ----------------------------------------------------------------------------
`include "touch_swipe_gesture_detector_defines.svh"

module tsgd_step #(
	parameter int COORD_BITS = tsgd_pkg::COORD_BITS_DEF,
	parameter int TIME_BITS  = tsgd_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  tsgd_pkg::cfg_t              cfg,
	input  logic                        create_pressed,
	input  logic                        click_pressed,
	input  logic                        first_down,
	input  logic [tsgd_pkg::ID_W-1:0]   first_id,
	input  logic [COORD_BITS-1:0]       first_x,
	input  logic [COORD_BITS-1:0]       first_y,
	input  logic                        second_down,
	input  logic [COORD_BITS-1:0]       second_x,
	input  logic [TIME_BITS-1:0]        now_ms,
	output logic [tsgd_pkg::GEST_W-1:0] gesture
);

	localparam int CMP_W = (COORD_BITS > tsgd_pkg::MID_W) ? COORD_BITS : tsgd_pkg::MID_W;

	logic                      prev_create_q;
	logic                      prev_click_q;
	logic                      stroke_active_q;
	logic                      suppress_q;
	logic [tsgd_pkg::ID_W-1:0] stroke_id_q;
	logic [COORD_BITS-1:0]     start_x_q;
	logic [COORD_BITS-1:0]     start_y_q;
	logic [COORD_BITS-1:0]     recent_x_q;
	logic [COORD_BITS-1:0]     recent_y_q;
	logic [TIME_BITS-1:0]      start_time_q;

	logic                      prev_create_d;
	logic                      prev_click_d;
	logic                      stroke_active_d;
	logic                      suppress_d;
	logic                      restart;
	logic                      track;

	logic                      any_down;
	logic                      create_rise;
	logic                      click_rise;
	logic [COORD_BITS-1:0]     click_x;
	logic [tsgd_pkg::GEST_W-1:0] swipe_gesture;

	assign any_down    = first_down || second_down;
	assign create_rise = create_pressed && !prev_create_q;
	assign click_rise  = click_pressed && !prev_click_q;
	assign click_x     = first_down ? first_x : second_x;

	tsgd_swipe #(
		.COORD_BITS (COORD_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_swipe (
		.start_x    (start_x_q),
		.start_y    (start_y_q),
		.recent_x   (recent_x_q),
		.recent_y   (recent_y_q),
		.start_time (start_time_q),
		.now_ms     (now_ms),
		.min_dist   (cfg.min_dist),
		.timeout    (cfg.timeout),
		.gesture    (swipe_gesture)
	);

	// Priority: create edge, then click, then suppression, then stroke tracking.
	always_comb begin
		gesture         = tsgd_pkg::G_NONE;
		prev_create_d   = create_pressed;
		prev_click_d    = prev_click_q;
		stroke_active_d = stroke_active_q;
		suppress_d      = suppress_q;
		restart         = 1'b0;
		track           = 1'b0;
		if (create_rise) begin
			gesture = tsgd_pkg::G_CREATE;
		end else if (click_rise) begin
			prev_click_d    = 1'b1;
			stroke_active_d = 1'b0;
			suppress_d      = 1'b1;
			if (any_down && (CMP_W'(click_x) >= CMP_W'(cfg.midpoint))) begin
				gesture = tsgd_pkg::G_RCLICK;
			end else begin
				gesture = tsgd_pkg::G_LCLICK;
			end
		end else if (click_pressed) begin
			gesture = tsgd_pkg::G_NONE;
		end else if (prev_click_q) begin
			prev_click_d = 1'b0;
		end else if (suppress_q) begin
			suppress_d = any_down;
		end else if (first_down) begin
			track = 1'b1;
			if (!stroke_active_q || (first_id != stroke_id_q)) begin
				restart         = 1'b1;
				stroke_active_d = 1'b1;
			end
		end else if (stroke_active_q) begin
			stroke_active_d = 1'b0;
			gesture         = swipe_gesture;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_create_q   <= 1'b0;
			prev_click_q    <= 1'b0;
			stroke_active_q <= 1'b0;
			suppress_q      <= 1'b0;
		end else if (fire) begin
			prev_create_q   <= prev_create_d;
			prev_click_q    <= prev_click_d;
			stroke_active_q <= stroke_active_d;
			suppress_q      <= suppress_d;
		end
	end

	// Stroke position and timing, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stroke_id_q  <= '0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			recent_x_q   <= '0;
			recent_y_q   <= '0;
			start_time_q <= '0;
		end else if (fire) begin
			if (restart) begin
				stroke_id_q  <= first_id;
				start_x_q    <= first_x;
				start_y_q    <= first_y;
				start_time_q <= now_ms;
			end
			if (track) begin
				recent_x_q <= first_x;
				recent_y_q <= first_y;
			end
		end
	end

	// A click cancels the stroke, so tracking and suppression never overlap.
	`TSGD_ASSERT_NOW(a_suppress_excl, suppress_q, !stroke_active_q, "stroke active while suppressed")
	// A click edge arms suppression and drops the stroke.
	`TSGD_ASSERT_NEXT(a_click_arms, fire && !create_rise && click_rise, suppress_q && !stroke_active_q && prev_click_q, "click edge did not arm suppression")
	// A swipe ends the stroke.
	`TSGD_ASSERT_NEXT(a_swipe_ends, fire && (gesture == tsgd_pkg::G_UP || gesture == tsgd_pkg::G_DOWN || gesture == tsgd_pkg::G_LEFT || gesture == tsgd_pkg::G_RIGHT), !stroke_active_q, "stroke still active after swipe")

endmodule

// ===== rtl/touch_swipe_gesture_detector.sv =====
// ----------------------------------------------------------------------------
// Touch swipe gesture detector
// Turns decoded touchpad samples into create, click and swipe gesture codes.
// ----------------------------------------------------------------------------
// One sample request enters on the input channel (in_valid / in_stall) and
// exactly one gesture code leaves on the output channel (out_valid /
// out_stall), in order. A sample is taken at a clock edge with in_valid high
// and in_stall low; a gesture is taken with out_valid high and out_stall low.
// The sample lands in an input register, one pass of compare and subtract
// logic updates the tracking state and fills the output register, which
// shows the gesture. A new sample can be taken every cycle while the output
// register is free; the input register and the single-pass logic set that
// rate. While the receiver stalls, the shown gesture holds, one more sample
// still enters the input register, and in_stall rises only when both
// registers are full. The configuration port (cfg_we, cfg_index, cfg_data)
// writes a register at each edge with cfg_we high; the user must use it only
// while no request is in flight, which the block itself does not enforce.
// Reset clears all tracking state, empties both registers and loads the
// configuration defaults: distance 300, timeout 1200 ms, midpoint 960.
// ----------------------------------------------------------------------------
`include "touch_swipe_gesture_detector_defines.svh"

module touch_swipe_gesture_detector #(
	parameter int COORD_BITS = tsgd_pkg::COORD_BITS_DEF,
	parameter int TIME_BITS  = tsgd_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration port.
	input  logic                           cfg_we,
	input  logic [tsgd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsgd_pkg::CFG_W-1:0]     cfg_data,
	// Sample channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           create_pressed,
	input  logic                           click_pressed,
	input  logic                           first_down,
	input  logic [tsgd_pkg::ID_W-1:0]      first_id,
	input  logic [COORD_BITS-1:0]          first_x,
	input  logic [COORD_BITS-1:0]          first_y,
	input  logic                           second_down,
	input  logic [COORD_BITS-1:0]          second_x,
	input  logic [TIME_BITS-1:0]           now_ms,
	// Gesture channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tsgd_pkg::GEST_W-1:0]    gesture
);

	tsgd_pkg::cfg_t              cfg;

	logic                        valid_s1;
	logic                        create_s1;
	logic                        click_s1;
	logic                        first_down_s1;
	logic [tsgd_pkg::ID_W-1:0]   first_id_s1;
	logic [COORD_BITS-1:0]       first_x_s1;
	logic [COORD_BITS-1:0]       first_y_s1;
	logic                        second_down_s1;
	logic [COORD_BITS-1:0]       second_x_s1;
	logic [TIME_BITS-1:0]        now_s1;

	logic                        valid_s2;
	logic [tsgd_pkg::GEST_W-1:0] gesture_s2;
	logic [tsgd_pkg::GEST_W-1:0] step_gesture;

	logic                        out_free;
	logic                        advance;
	logic                        take;

	tsgd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake: the input register moves on when the output register is free.
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take     = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			create_s1      <= create_pressed;
			click_s1       <= click_pressed;
			first_down_s1  <= first_down;
			first_id_s1    <= first_id;
			first_x_s1     <= first_x;
			first_y_s1     <= first_y;
			second_down_s1 <= second_down;
			second_x_s1    <= second_x;
			now_s1         <= now_ms;
		end
	end

	tsgd_step #(
		.COORD_BITS (COORD_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (advance),
		.cfg            (cfg),
		.create_pressed (create_s1),
		.click_pressed  (click_s1),
		.first_down     (first_down_s1),
		.first_id       (first_id_s1),
		.first_x        (first_x_s1),
		.first_y        (first_y_s1),
		.second_down    (second_down_s1),
		.second_x       (second_x_s1),
		.now_ms         (now_s1),
		.gesture        (step_gesture)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_s2 <= step_gesture;
		end
	end

	assign out_valid = valid_s2;
	assign gesture   = gesture_s2;

	// The input side only stalls when a sample is parked in the input register.
	`TSGD_ASSERT_NOW(a_stall_needs_s1, in_stall, valid_s1, "stall with empty input register")
	// A parked sample that cannot move on stays in the input register.
	`TSGD_ASSERT_NEXT(a_s1_kept, valid_s1 && !advance, valid_s1, "parked sample lost")
	// Every processed sample produces a shown gesture.
	`TSGD_ASSERT_NEXT(a_result_shown, advance, valid_s2, "processed sample gave no gesture")

endmodule

// ===== tb/touch_swipe_gesture_detector_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch swipe gesture detector testbench
// Sends touchpad sample requests through the valid/stall channel and checks
// every gesture code against a cycle-free model of the detector kept here.
// Directed cases come first, then register extremes, a long hold-off on the
// gesture side and several phases of random strokes, clicks and noise.
// ----------------------------------------------------------------------------
module touch_swipe_gesture_detector_test;

	localparam int CW   = tsgd_pkg::COORD_BITS_DEF;
	localparam int TW   = tsgd_pkg::TIME_BITS_DEF;
	localparam int IDW  = tsgd_pkg::ID_W;
	localparam int GW   = tsgd_pkg::GEST_W;
	localparam int DW   = tsgd_pkg::DIST_W;
	localparam int TMW  = tsgd_pkg::TMO_W;
	localparam int MW   = tsgd_pkg::MID_W;
	localparam int CFGW = tsgd_pkg::CFG_W;
	localparam int IXW  = tsgd_pkg::CFG_IDX_W;
	localparam int LATENCY = 2;
	localparam int RUN_LIMIT_NS = 10_000_000;
	localparam int MAX_REPORTS = 100;

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

	// One touchpad sample as the predictor sees it.
	typedef struct {
		logic           create_lvl;
		logic           click_lvl;
		logic           f_down;
		logic [IDW-1:0] f_id;
		logic [CW-1:0]  f_x;
		logic [CW-1:0]  f_y;
		logic           s_down;
		logic [CW-1:0]  s_x;
		logic [TW-1:0]  now;
	} touch_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [IXW-1:0]  cfg_index;
	logic [CFGW-1:0] cfg_data;
	logic            in_valid;
	logic            in_stall;
	logic            create_pressed;
	logic            click_pressed;
	logic            first_down;
	logic [IDW-1:0]  first_id;
	logic [CW-1:0]   first_x;
	logic [CW-1:0]   first_y;
	logic            second_down;
	logic [CW-1:0]   second_x;
	logic [TW-1:0]   now_ms;
	logic            out_valid;
	logic            out_stall;
	logic [GW-1:0]   gesture;

	// Predictor copy of the configuration and tracking state.
	logic [DW-1:0]  cfg_min_dist;
	logic [TMW-1:0] cfg_timeout;
	logic [MW-1:0]  cfg_midpoint;
	logic           last_create_lvl;
	logic           last_click_lvl;
	logic           tracking;
	logic           touch_blocked;
	logic [IDW-1:0] track_id;
	logic [CW-1:0]  origin_x;
	logic [CW-1:0]  origin_y;
	logic [CW-1:0]  latest_x;
	logic [CW-1:0]  latest_y;
	logic [TW-1:0]  origin_ms;

	// Gesture codes still owed by the block, oldest first.
	logic [GW-1:0] pending_gestures[$];
	logic [GW-1:0] due_gesture;

	// Stimulus levels and traffic shaping.
	logic          btn_create;
	logic          btn_click;
	logic [TW-1:0] clock_ms;
	int            touches_sent;
	int            burst_left;
	int            burst_max;
	int            gap_max;
	int            hold_request;
	int            mismatches;
	stall_mode_t   stall_mode;

	touch_swipe_gesture_detector dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.create_pressed (create_pressed),
		.click_pressed  (click_pressed),
		.first_down     (first_down),
		.first_id       (first_id),
		.first_x        (first_x),
		.first_y        (first_y),
		.second_down    (second_down),
		.second_x       (second_x),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.gesture        (gesture)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Random single bit.
	function automatic logic coin();
		return $urandom_range(0, 1) == 1;
	endfunction

	// Swipe decision for a stroke that ends at time now.
	function automatic logic [GW-1:0] swipe_direction(input logic [TW-1:0] now);
		int lx, ly, ox, oy, dx, dy, ax, ay, big, floor_dist;
		logic [TW-1:0] elapsed;
		lx = int'(latest_x);
		ly = int'(latest_y);
		ox = int'(origin_x);
		oy = int'(origin_y);
		dx = lx - ox;
		dy = ly - oy;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		big = (ax > ay) ? ax : ay;
		floor_dist = int'(cfg_min_dist);
		elapsed = now - origin_ms;
		if (elapsed > cfg_timeout || big < floor_dist)
			return tsgd_pkg::G_NONE;
		if (ax >= ay)
			return (dx >= 0) ? tsgd_pkg::G_RIGHT : tsgd_pkg::G_LEFT;
		return (dy >= 0) ? tsgd_pkg::G_DOWN : tsgd_pkg::G_UP;
	endfunction

	// Gesture the block owes for one sample; updates the tracking state.
	function automatic logic [GW-1:0] predict_gesture(input touch_t t);
		logic          any_down;
		logic [CW-1:0] click_x;
		any_down = t.f_down | t.s_down;
		if (t.create_lvl != last_create_lvl) begin
			last_create_lvl = t.create_lvl;
			if (t.create_lvl)
				return tsgd_pkg::G_CREATE;
		end
		if (t.click_lvl && !last_click_lvl) begin
			click_x = t.f_down ? t.f_x : t.s_x;
			last_click_lvl = 1'b1;
			tracking = 1'b0;
			touch_blocked = 1'b1;
			return (any_down && click_x >= cfg_midpoint) ? tsgd_pkg::G_RCLICK :
				tsgd_pkg::G_LCLICK;
		end
		if (t.click_lvl)
			return tsgd_pkg::G_NONE;
		if (last_click_lvl) begin
			last_click_lvl = 1'b0;
			return tsgd_pkg::G_NONE;
		end
		if (touch_blocked) begin
			if (!any_down)
				touch_blocked = 1'b0;
			return tsgd_pkg::G_NONE;
		end
		if (t.f_down) begin
			if (!tracking || t.f_id != track_id) begin
				tracking = 1'b1;
				track_id = t.f_id;
				origin_x = t.f_x;
				origin_y = t.f_y;
				origin_ms = t.now;
			end
			latest_x = t.f_x;
			latest_y = t.f_y;
			return tsgd_pkg::G_NONE;
		end
		if (!tracking)
			return tsgd_pkg::G_NONE;
		tracking = 1'b0;
		return swipe_direction(t.now);
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_REPORTS)
			$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Send one sample request with the current button levels, then idle
	// between bursts when gaps are enabled.
	task automatic send_touch(input logic f_down, input int id, input int x, input int y,
			input logic s_down, input int s_x, input logic [TW-1:0] now);
		touch_t t;
		int gap;
		t.create_lvl = btn_create;
		t.click_lvl = btn_click;
		t.f_down = f_down;
		t.f_id = IDW'(id);
		t.f_x = CW'(x);
		t.f_y = CW'(y);
		t.s_down = s_down;
		t.s_x = CW'(s_x);
		t.now = now;
		clock_ms = now;
		create_pressed <= t.create_lvl;
		click_pressed <= t.click_lvl;
		first_down <= t.f_down;
		first_id <= t.f_id;
		first_x <= t.f_x;
		first_y <= t.f_y;
		second_down <= t.s_down;
		second_x <= t.s_x;
		now_ms <= t.now;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_gestures.push_back(predict_gesture(t));
		touches_sent++;
		if (gap_max > 0) begin
			burst_left--;
			if (burst_left <= 0) begin
				in_valid <= 1'b0;
				gap = $urandom_range(1, gap_max);
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, burst_max);
			end
		end
	endtask

	// Hold off new requests until every owed gesture has been taken.
	task automatic wait_for_gestures();
		in_valid <= 1'b0;
		while (pending_gestures.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IXW-1:0] idx, input logic [CFGW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tsgd_pkg::REG_MIN_DIST: cfg_min_dist = data[DW-1:0];
			tsgd_pkg::REG_TIMEOUT:  cfg_timeout = data[TMW-1:0];
			tsgd_pkg::REG_MIDPOINT: cfg_midpoint = data[MW-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_traffic(input stall_mode_t mode, input int bursts, input int gaps);
		stall_mode = mode;
		burst_max = bursts;
		gap_max = gaps;
		burst_left = 1;
	endtask

	// Start of a travel of length span that stays on the pad.
	function automatic int fit_start(input int span, input logic neg);
		return neg ? $urandom_range(span, 4095) : $urandom_range(0, 4095 - span);
	endfunction

	// Coordinate at or right next to the click midpoint.
	function automatic int near_midpoint();
		int v;
		v = int'(cfg_midpoint);
		v = v + $urandom_range(0, 2) - 1;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v;
	endfunction

	// A well-formed stroke: touch down, wander, end point, release.
	// Travel and duration cluster around the configured limits.
	task automatic random_stroke();
		int d, cd, a0, a1, b0, b1, dur, moves, tmo, floor_dist, cur_id;
		logic horiz, neg, cneg;
		logic [TW-1:0] t0;
		floor_dist = int'(cfg_min_dist);
		tmo = int'(cfg_timeout);
		case ($urandom_range(0, 4))
			0: d = floor_dist;
			1: d = floor_dist - 1;
			2: d = $urandom_range(floor_dist, 4095);
			default: d = $urandom_range(0, 4095);
		endcase
		if (d < 0)
			d = 0;
		horiz = coin();
		neg = coin();
		a0 = fit_start(d, neg);
		a1 = neg ? a0 - d : a0 + d;
		// Cross axis mostly travels less, sometimes ties, sometimes anything.
		cd = ($urandom_range(0, 3) == 0) ? d : $urandom_range(0, d);
		cneg = coin();
		b0 = fit_start(cd, cneg);
		b1 = cneg ? b0 - cd : b0 + cd;
		if ($urandom_range(0, 5) == 0)
			b1 = $urandom_range(0, 4095);
		case ($urandom_range(0, 3))
			0: dur = tmo;
			1: dur = tmo + 1;
			2: dur = $urandom_range(0, tmo);
			default: dur = $urandom_range(0, 200000);
		endcase
		// Start time, now and then right before the clock wraps.
		case ($urandom_range(0, 15))
			0: t0 = $urandom();
			1: t0 = 32'hFFFF_FFFF - $urandom_range(0, 2000);
			default: t0 = clock_ms + $urandom_range(1, 5000);
		endcase
		cur_id = $urandom_range(0, 127);
		if (horiz)
			send_touch(1'b1, cur_id, a0, b0, $urandom_range(0, 3) == 0, $urandom(), t0);
		else
			send_touch(1'b1, cur_id, b0, a0, $urandom_range(0, 3) == 0, $urandom(), t0);
		moves = $urandom_range(0, 3);
		repeat (moves) begin
			if ($urandom_range(0, 7) == 0)
				cur_id = $urandom_range(0, 127);
			send_touch(1'b1, cur_id, $urandom(), $urandom(), coin(),
				$urandom(), t0 + $urandom_range(0, dur));
		end
		if (horiz)
			send_touch(1'b1, cur_id, a1, b1, 1'b0, $urandom(), t0 + $urandom_range(0, dur));
		else
			send_touch(1'b1, cur_id, b1, a1, 1'b0, $urandom(), t0 + $urandom_range(0, dur));
		send_touch(1'b0, $urandom(), $urandom(), $urandom(), coin(),
			$urandom(), t0 + dur);
	endtask

	// Press, hold, release, suppressed touches and usually a lift-off.
	task automatic random_click();
		int fx, sx;
		int extra;
		fx = coin() ? near_midpoint() : $urandom_range(0, 4095);
		sx = coin() ? near_midpoint() : $urandom_range(0, 4095);
		btn_click = 1'b1;
		send_touch(coin(), $urandom(), fx, $urandom(), coin(),
			sx, clock_ms + $urandom_range(1, 300));
		extra = $urandom_range(0, 2);
		repeat (extra)
			send_touch(coin(), $urandom(), $urandom(), $urandom(),
				coin(), $urandom(), clock_ms + $urandom_range(1, 300));
		btn_click = 1'b0;
		send_touch(coin(), $urandom(), $urandom(), $urandom(),
			coin(), $urandom(), clock_ms + $urandom_range(1, 300));
		extra = $urandom_range(0, 2);
		repeat (extra)
			send_touch(1'b1, $urandom(), $urandom(), $urandom(), coin(),
				$urandom(), clock_ms + $urandom_range(1, 300));
		if ($urandom_range(0, 4) != 0)
			send_touch(1'b0, $urandom(), $urandom(), $urandom(), 1'b0, $urandom(),
				clock_ms + $urandom_range(1, 300));
	endtask

	// Toggle the create button over an arbitrary touch state.
	task automatic random_create();
		btn_create = ~btn_create;
		send_touch(coin(), $urandom(), $urandom(), $urandom(),
			coin(), $urandom(), clock_ms + $urandom_range(1, 300));
	endtask

	// A sample with every field random, button levels included.
	task automatic random_noise();
		btn_create = coin();
		btn_click = coin();
		send_touch(coin(), $urandom(), $urandom(), $urandom(),
			coin(), $urandom(), $urandom());
		btn_click = 1'b0;
	endtask

	task automatic random_mix(input int count);
		int goal, pick;
		goal = touches_sent + count;
		while (touches_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 62)
				random_stroke();
			else if (pick < 76)
				random_click();
			else if (pick < 86)
				random_create();
			else
				random_noise();
		end
	endtask

	// Edge cases of strokes, clicks and the create button at reset settings.
	task automatic test_directed_gestures();
		set_traffic(STALL_NONE, 1, 0);
		// Release with no stroke, then a create press that hides the touch.
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 0);
		btn_create = 1'b1;
		send_touch(1'b1, 0, 0, 0, 1'b0, 0, 0);
		send_touch(1'b1, 0, 0, 0, 1'b0, 0, 100);
		btn_create = 1'b0;
		send_touch(1'b1, 0, 4095, 0, 1'b0, 0, 500);
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 1300);
		// An id change restarts the stroke; up by exactly the minimum travel.
		send_touch(1'b1, 127, 4095, 4095, 1'b1, 4095, 2000);
		send_touch(1'b1, 5, 2000, 2000, 1'b0, 0, 2100);
		send_touch(1'b1, 5, 2000, 1700, 1'b0, 0, 2200);
		send_touch(1'b0, 5, 4095, 4095, 1'b1, 0, 3300);
		// Equal travel on both axes goes horizontal.
		set_traffic(STALL_RANDOM, 3, 2);
		send_touch(1'b1, 9, 1000, 1000, 1'b0, 0, 4000);
		send_touch(1'b1, 9, 700, 1300, 1'b0, 0, 4500);
		send_touch(1'b0, 9, 0, 0, 1'b0, 0, 5200);
		// One millisecond over the timeout is rejected.
		send_touch(1'b1, 9, 500, 500, 1'b0, 0, 6000);
		send_touch(1'b1, 9, 500, 900, 1'b0, 0, 6100);
		send_touch(1'b0, 9, 0, 0, 1'b0, 0, 7201);
		// A downward stroke across the clock wrap.
		send_touch(1'b1, 64, 100, 0, 1'b0, 0, 32'hFFFF_FF00);
		send_touch(1'b1, 64, 100, 4095, 1'b0, 0, 32'hFFFF_FFFF);
		send_touch(1'b0, 64, 0, 0, 1'b0, 0, 32'h0000_03A0);
		// Click during a stroke cancels it; held and released clicks give none.
		send_touch(1'b1, 3, 0, 0, 1'b0, 0, 8000);
		btn_click = 1'b1;
		send_touch(1'b1, 3, 0, 0, 1'b1, 4095, 8010);
		send_touch(1'b1, 3, 4095, 4095, 1'b0, 0, 8020);
		btn_click = 1'b0;
		send_touch(1'b1, 3, 4095, 0, 1'b0, 0, 8030);
		send_touch(1'b1, 3, 4095, 0, 1'b0, 0, 9000);
		// Click side: midpoint exactly, first finger wins, second finger, none.
		btn_click = 1'b1;
		send_touch(1'b1, 3, 960, 0, 1'b0, 0, 9010);
		btn_click = 1'b0;
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 9020);
		btn_click = 1'b1;
		send_touch(1'b1, 3, 959, 0, 1'b1, 4095, 9030);
		btn_click = 1'b0;
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 9040);
		btn_click = 1'b1;
		send_touch(1'b0, 0, 0, 0, 1'b1, 960, 9050);
		btn_click = 1'b0;
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 9060);
		btn_click = 1'b1;
		send_touch(1'b0, 0, 4095, 4095, 1'b0, 4095, 9070);
		btn_click = 1'b0;
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 9080);
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 9090);
		// Create and click rise together: create now, click on the next one.
		btn_create = 1'b1;
		btn_click = 1'b1;
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 9100);
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 9110);
		btn_create = 1'b0;
		btn_click = 1'b0;
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 9120);
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 9130);
		wait_for_gestures();
	endtask

	// Every register at both ends of its range, then back to reset values.
	task automatic test_register_extremes();
		set_traffic(STALL_PATTERN, 6, 3);
		// Bits above a register's width are dropped.
		write_reg(tsgd_pkg::REG_MIN_DIST, 16'hF000);
		write_reg(tsgd_pkg::REG_TIMEOUT, 16'hFFFF);
		write_reg(tsgd_pkg::REG_MIDPOINT, 16'h0000);
		// Zero travel counts as a swipe to the right.
		send_touch(1'b1, 7, 2048, 2048, 1'b0, 0, 100);
		send_touch(1'b0, 7, 0, 0, 1'b0, 0, 100 + 65535);
		// With the midpoint at zero only a lifted pad still gives a left click.
		btn_click = 1'b1;
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 70000);
		btn_click = 1'b0;
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 70010);
		btn_click = 1'b1;
		send_touch(1'b1, 0, 0, 0, 1'b0, 0, 70020);
		btn_click = 1'b0;
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 70030);
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 70040);
		repeat (40) random_stroke();
		wait_for_gestures();

		write_reg(tsgd_pkg::REG_MIN_DIST, 16'h0FFF);
		write_reg(tsgd_pkg::REG_TIMEOUT, 16'h0000);
		write_reg(tsgd_pkg::REG_MIDPOINT, 16'hFFFF);
		// Full diagonal at zero elapsed time passes; one millisecond fails.
		send_touch(1'b1, 1, 0, 0, 1'b0, 0, 5000);
		send_touch(1'b1, 1, 4095, 4095, 1'b0, 0, 5000);
		send_touch(1'b0, 1, 0, 0, 1'b0, 0, 5000);
		send_touch(1'b1, 2, 4095, 0, 1'b0, 0, 6000);
		send_touch(1'b1, 2, 0, 0, 1'b0, 0, 6000);
		send_touch(1'b0, 2, 0, 0, 1'b0, 0, 6001);
		btn_click = 1'b1;
		send_touch(1'b1, 2, 4095, 0, 1'b0, 0, 6010);
		btn_click = 1'b0;
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 6020);
		btn_click = 1'b1;
		send_touch(1'b1, 2, 4094, 0, 1'b1, 4095, 6030);
		btn_click = 1'b0;
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 6040);
		send_touch(1'b0, 0, 0, 0, 1'b0, 0, 6050);
		repeat (40) random_stroke();
		wait_for_gestures();

		write_reg(tsgd_pkg::REG_MIN_DIST, CFGW'(tsgd_pkg::MIN_DIST_RST));
		write_reg(tsgd_pkg::REG_TIMEOUT, CFGW'(tsgd_pkg::TIMEOUT_RST));
		write_reg(tsgd_pkg::REG_MIDPOINT, CFGW'(tsgd_pkg::MIDPOINT_RST));
	endtask

	// The gesture side holds off long enough for the input to back up.
	task automatic test_receiver_hold();
		set_traffic(STALL_NONE, 1, 0);
		hold_request = 120;
		random_mix(30);
		wait_for_gestures();
		set_traffic(STALL_RANDOM, 8, 3);
		hold_request = 200;
		random_mix(20);
		wait_for_gestures();
	endtask

	// Random traffic in phases, each with its own settings and idling.
	task automatic test_random_traffic();
		int phase;
		for (phase = 0; phase < 6; phase++) begin
			wait_for_gestures();
			if (phase != 0) begin
				write_reg(tsgd_pkg::REG_MIN_DIST, CFGW'(($urandom_range(0, 3) == 0) ?
					($urandom_range(0, 1) ? 4095 : 0) : $urandom_range(0, 800)));
				write_reg(tsgd_pkg::REG_TIMEOUT, CFGW'(($urandom_range(0, 3) == 0) ?
					($urandom_range(0, 1) ? 65535 : 0) : $urandom_range(0, 3000)));
				write_reg(tsgd_pkg::REG_MIDPOINT, CFGW'($urandom_range(0, 4095)));
			end
			case (phase)
				0: set_traffic(STALL_NONE, 1, 0);
				1: set_traffic(STALL_RANDOM, 12, 4);
				2: set_traffic(STALL_PATTERN, 4, 2);
				3: set_traffic(STALL_HEAVY, 1, 0);
				4: set_traffic(STALL_NONE, 30, 8);
				default: set_traffic(STALL_RANDOM, 6, 6);
			endcase
			random_mix(75);
		end
		wait_for_gestures();
	endtask

	// Gesture side: stall pattern, with a counted hold-off on request.
	initial begin : gesture_receiver
		int hold_left;
		int beat;
		hold_left = 0;
		beat = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			beat++;
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 30);
					STALL_PATTERN: out_stall <= ((beat % 7) < 3);
					STALL_HEAVY:   out_stall <= ($urandom_range(0, 99) < 75);
					default:       out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Compare each taken gesture with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_gestures.size() == 0) begin
				report_mismatch($sformatf("gesture %0d with none owed", gesture));
			end else begin
				due_gesture = pending_gestures.pop_front();
				if (gesture !== due_gesture)
					report_mismatch($sformatf("gesture %0d, owed %0d", gesture, due_gesture));
			end
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	initial begin
		cfg_min_dist = tsgd_pkg::MIN_DIST_RST;
		cfg_timeout = tsgd_pkg::TIMEOUT_RST;
		cfg_midpoint = tsgd_pkg::MIDPOINT_RST;
		last_create_lvl = 1'b0;
		last_click_lvl = 1'b0;
		tracking = 1'b0;
		touch_blocked = 1'b0;
		track_id = '0;
		origin_x = '0;
		origin_y = '0;
		latest_x = '0;
		latest_y = '0;
		origin_ms = '0;
		btn_create = 1'b0;
		btn_click = 1'b0;
		clock_ms = '0;
		touches_sent = 0;
		hold_request = 0;
		mismatches = 0;
		set_traffic(STALL_NONE, 1, 0);

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= tsgd_pkg::REG_MIN_DIST;
		cfg_data <= '0;
		in_valid <= 1'b0;
		create_pressed <= 1'b0;
		click_pressed <= 1'b0;
		first_down <= 1'b0;
		first_id <= '0;
		first_x <= '0;
		first_y <= '0;
		second_down <= 1'b0;
		second_x <= '0;
		now_ms <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_gestures();
		test_register_extremes();
		test_receiver_hold();
		test_random_traffic();

		// Let any stray gesture show up before the verdict.
		repeat (LATENCY * 8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
